// ===== design/assert_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent holds in this cycle, consequent in the next one.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/cpa_pkg.sv =====
// Shared widths, codes and defaults of the page allocator.
package cpa_pkg;

  localparam int unsigned PAGES_DEF = 4096;
  localparam int unsigned REGIONS   = 3;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned RSEL_W  = 2;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned PAGE_W  = 12;
  localparam int unsigned STAT_W  = 2;
  // internal page arithmetic, wide enough for start + step overshoot
  localparam int unsigned WIDE_W  = 17;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 3'd0,
    ACT_ALIGNED = 3'd1,
    ACT_FREE    = 3'd2,
    ACT_RESERVE = 3'd3,
    ACT_COUNT   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_NOREGION = 2'd3
  } status_e;

endpackage

// ===== design/cpa_ifs.sv =====
// Request and response channel interfaces of the page allocator.
interface cpa_req_if
  import cpa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [RSEL_W-1:0] region_select;
  logic [CNT_W-1:0]  page_count_req;
  logic [CNT_W-1:0]  alignment_pages;
  logic [PAGE_W-1:0] page_address;

  modport source (output valid, action, region_select, page_count_req,
                  alignment_pages, page_address, input ready);
  modport sink   (input valid, action, region_select, page_count_req,
                  alignment_pages, page_address, output ready);
endinterface

interface cpa_rsp_if
  import cpa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PAGE_W-1:0] page_index;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, status, page_index, free_count, input ready);
  modport sink   (input valid, status, page_index, free_count, output ready);
endinterface

// ===== design/cpa_bitmap.sv =====
// Page used-bit memory, one write port and one registered read port.
module cpa_bitmap #(
  parameter int unsigned PAGES = 4096,
  localparam int unsigned AW   = $clog2(PAGES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [PAGES];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/contiguous_page_allocator_unit.sv =====
// Top level of the first-fit page allocator.
//
//  channel | dir | handshake           | word
//  req     | in  | valid/ready         | action, region, count, alignment, address
//  rsp     | out | valid/ready         | status, page index, free count
//  apb     | in  | psel/penable/pready | eight region/memory registers
//
// One page of the bitmap is checked per visit to S_RD and S_CHK (read, then test),
// and marking a run writes its pages one at a time in S_MARK.
// After reset a clearing pass over all PAGES pages zeroes the bitmap; no request
// is taken meanwhile. A request is taken only when the block is idle; a
// finished word waits in the output register until taken.
`include "assert_macros.svh"
module contiguous_page_allocator_unit
  import cpa_pkg::*;
#(
  parameter int unsigned PAGES = PAGES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpa_req_if.sink      req,
  cpa_rsp_if.source    rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned AW = $clog2(PAGES);

  typedef enum logic [2:0] {
    REG_R0_START = 3'd0, REG_R0_PAGES = 3'd1,
    REG_R1_START = 3'd2, REG_R1_PAGES = 3'd3,
    REG_R2_START = 3'd4, REG_R2_PAGES = 3'd5,
    REG_ENABLE   = 3'd6, REG_TOTAL    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_CHK, S_MARK, S_DONE
  } state_e;

  // ---------------- configuration registers
  logic [PAGE_W-1:0]  rstart_q [REGIONS];
  logic [CNT_W-1:0]   rpages_q [REGIONS];
  logic [REGIONS-1:0] renable_q;
  logic [CNT_W-1:0]   total_q;
  reg_e               preg;

  assign preg   = reg_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < REGIONS; r++) begin
        rstart_q[r] <= '0;
        rpages_q[r] <= '0;
      end
      renable_q <= '0;
      total_q   <= '0;
    end else if (psel && penable && pwrite) begin
      case (preg)
        REG_R0_START: rstart_q[0] <= pwdata[PAGE_W-1:0];
        REG_R0_PAGES: rpages_q[0] <= pwdata[CNT_W-1:0];
        REG_R1_START: rstart_q[1] <= pwdata[PAGE_W-1:0];
        REG_R1_PAGES: rpages_q[1] <= pwdata[CNT_W-1:0];
        REG_R2_START: rstart_q[2] <= pwdata[PAGE_W-1:0];
        REG_R2_PAGES: rpages_q[2] <= pwdata[CNT_W-1:0];
        REG_ENABLE:   renable_q   <= pwdata[REGIONS-1:0];
        REG_TOTAL:    total_q     <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (preg)
      REG_R0_START: prdata = 32'(rstart_q[0]);
      REG_R0_PAGES: prdata = 32'(rpages_q[0]);
      REG_R1_START: prdata = 32'(rstart_q[1]);
      REG_R1_PAGES: prdata = 32'(rpages_q[1]);
      REG_R2_START: prdata = 32'(rstart_q[2]);
      REG_R2_PAGES: prdata = 32'(rpages_q[2]);
      REG_ENABLE:   prdata = 32'(renable_q);
      REG_TOTAL:    prdata = 32'(total_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- request decode (idle cycle only)
  logic [WIDE_W-1:0] mem_end, lo, hi, reg_end, align, align_m1, first, step, nrun;
  logic [WIDE_W-1:0] cnt_w, addr_w;
  logic [1:0]        rsel;
  logic              rsel_ok, in_region;

  always_comb begin
    mem_end = (WIDE_W'(total_q) < WIDE_W'(PAGES)) ? WIDE_W'(total_q) : WIDE_W'(PAGES);
    rsel    = (req.region_select < RSEL_W'(REGIONS)) ? req.region_select : 2'd0;
    rsel_ok = (req.region_select < RSEL_W'(REGIONS)) && renable_q[rsel];
    lo      = WIDE_W'(rstart_q[rsel]);
    reg_end = lo + WIDE_W'(rpages_q[rsel]);
    hi      = (reg_end > mem_end) ? mem_end : reg_end;
    if (hi < lo) begin
      hi = lo;
    end
    // alignment below a power of two acts as its highest set bit
    align = WIDE_W'(1);
    for (int i = 0; i < CNT_W; i++) begin
      if (req.alignment_pages[i]) begin
        align = WIDE_W'(1) << i;
      end
    end
    align_m1 = align - WIDE_W'(1);
    cnt_w    = WIDE_W'(req.page_count_req);
    addr_w   = WIDE_W'(req.page_address);
    first    = (lo + align_m1) & ~align_m1;
    step     = (cnt_w + align_m1) & ~align_m1;
    nrun     = (cnt_w > mem_end - addr_w) ? (mem_end - addr_w) : cnt_w;
    in_region = 1'b0;
    for (int r = 0; r < REGIONS; r++) begin
      if (renable_q[r] && addr_w >= WIDE_W'(rstart_q[r]) &&
          addr_w - WIDE_W'(rstart_q[r]) < WIDE_W'(rpages_q[r])) begin
        in_region = 1'b1;
      end
    end
  end

  // ---------------- sequencer
  state_e            state_q;
  action_e           op_q;
  logic [WIDE_W-1:0] cand_q, k_q, cnt_q, hi_q, step_q, end_q, ptr_q, nfree_q;
  logic              wval_q;
  logic [AW-1:0]     clr_q;
  logic [STAT_W-1:0] status_q, out_status_q;
  logic [PAGE_W-1:0] index_q, out_index_q;
  logic [CNT_W-1:0]  out_free_q;
  logic              out_valid_q;
  logic              rdata, is_count, past_end, run_done;
  logic [WIDE_W-1:0] scan_addr;

  assign is_count  = (op_q == ACT_COUNT);
  assign scan_addr = is_count ? cand_q : cand_q + k_q;
  assign past_end  = is_count ? (cand_q >= hi_q) : (cand_q + cnt_q > hi_q);
  assign run_done  = (k_q + WIDE_W'(1) == cnt_q);

  cpa_bitmap #(.PAGES(PAGES)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (state_q == S_CLR || state_q == S_MARK),
    .waddr_i (state_q == S_CLR ? clr_q : ptr_q[AW-1:0]),
    .wdata_i (state_q == S_CLR ? 1'b0 : wval_q),
    .re_i    (state_q == S_RD),
    .raddr_i (scan_addr[AW-1:0]),
    .rdata_o (rdata)
  );

  assign req.ready      = (state_q == S_IDLE);
  assign rsp.valid      = out_valid_q;
  assign rsp.status     = out_status_q;
  assign rsp.page_index = out_index_q;
  assign rsp.free_count = out_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= ACT_ALLOC;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (rsp.valid && rsp.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(PAGES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_q     <= action_e'(req.action);
            status_q <= ST_OK;
            index_q  <= '0;
            nfree_q  <= '0;
            cnt_q    <= cnt_w;
            k_q      <= '0;
            state_q  <= S_DONE;
            case (req.action)
              ACT_ALLOC, ACT_ALIGNED: begin
                if (!rsel_ok) begin
                  status_q <= ST_NOREGION;
                end else begin
                  status_q <= ST_NO_FIT;
                  hi_q     <= hi;
                  cand_q   <= (req.action == ACT_ALIGNED) ? first : lo;
                  step_q   <= step;
                  if (cnt_w != '0) begin
                    state_q <= S_RD;
                  end
                end
              end
              ACT_FREE, ACT_RESERVE: begin
                if (addr_w >= mem_end) begin
                  status_q <= ST_OUTSIDE;
                end else if (!in_region) begin
                  status_q <= ST_NOREGION;
                end else if (nrun != '0) begin
                  ptr_q   <= addr_w;
                  end_q   <= addr_w + nrun;
                  wval_q  <= (req.action == ACT_RESERVE);
                  state_q <= S_MARK;
                end
              end
              ACT_COUNT: begin
                cand_q  <= '0;
                hi_q    <= mem_end;
                state_q <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state_q <= past_end ? S_DONE : S_CHK;
        end
        S_CHK: begin
          state_q <= S_RD;
          if (is_count) begin
            if (!rdata) begin
              nfree_q <= nfree_q + WIDE_W'(1);
            end
            cand_q <= cand_q + WIDE_W'(1);
          end else if (!rdata) begin
            if (run_done) begin
              status_q <= ST_OK;
              index_q  <= cand_q[PAGE_W-1:0];
              ptr_q    <= cand_q;
              end_q    <= cand_q + cnt_q;
              wval_q   <= 1'b1;
              state_q  <= S_MARK;
            end else begin
              k_q <= k_q + WIDE_W'(1);
            end
          end else begin
            // used page: plain scan restarts past it, aligned scan steps on
            cand_q <= (op_q == ACT_ALIGNED) ? cand_q + step_q
                                            : cand_q + k_q + WIDE_W'(1);
            k_q    <= '0;
          end
        end
        S_MARK: begin
          ptr_q <= ptr_q + WIDE_W'(1);
          if (ptr_q + WIDE_W'(1) == end_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || rsp.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_index_q  <= index_q;
            out_free_q   <= nfree_q[CNT_W-1:0];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req.valid && req.ready, !req.ready)
  `ASSERT_NOW(a_no_req_in_clear, clk_i, rst_ni, state_q == S_CLR, !req.ready)
  `ASSERT_NOW(a_mark_in_run, clk_i, rst_ni, state_q == S_MARK, ptr_q < end_q)
  `ASSERT_NOW(a_probe_in_run, clk_i, rst_ni, state_q == S_CHK && !is_count, k_q < cnt_q)

endmodule
